// ----- hw/rtl/ubxr_pkg.sv -----
// Shared types and constants for the UBX frame receiver.
package ubxr_pkg;

  localparam logic [7:0] Sync1Byte = 8'hB5;
  localparam logic [7:0] Sync2Byte = 8'h62;
  localparam logic [7:0] ClassAck  = 8'h05;
  localparam logic [7:0] IdAck     = 8'h01;
  localparam logic [7:0] IdNack    = 8'h00;
  localparam logic [7:0] ClassNav  = 8'h01;
  localparam logic [7:0] IdNavPos  = 8'h02;

  localparam int unsigned TdataOutW = 88;

  // frame_status codes
  localparam logic [1:0] StatNone = 2'd0;
  localparam logic [1:0] StatGood = 2'd1;
  localparam logic [1:0] StatBad  = 2'd2;
  localparam logic [1:0] StatDrop = 2'd3;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [6:0]  payload_index;
    logic [1:0]  frame_status;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_length;
    logic        ack_seen;
    logic        nack_seen;
    logic [15:0] bad_frames;
    logic [15:0] position_frames;
  } result_t;

endpackage

// ----- hw/rtl/ubx_frame_receiver.sv -----
// Top level of the UBX frame receiver: input register, parser, result register.
//
// Usage:
//   s_axis carries one received serial byte per request in tdata[7:0].
//   m_axis returns exactly one result per input byte, in order, with the
//   payload byte and index, the frame end status, the header of the current
//   frame, ack/nack flags and the two wrapping frame counters.
//   Path: an accepted byte is held in the input register and parsed from
//   there; its result is captured in the result register driving m_axis.
//   Throughput: one byte per cycle while m_axis_tready_i is high; framing
//   and Fletcher sums update in one pass, input to result register.
//   Reset: all control state and counters clear; the parser starts hunting
//   for the sync pair.
//   Stall: when m_axis_tready_i is low the result register holds, the input
//   register fills, and s_axis_tready_o drops until the result is taken.
//   MAX_PAYLOAD sets the longest payload accepted; longer frames are dropped.
module ubx_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] rx_byte
  input  logic [7:0]  s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] payload_valid, [8:1] payload_byte, [15:9] payload_index,
  // [17:16] frame_status, [25:18] msg_class, [33:26] msg_id,
  // [49:34] payload_length, [50] ack_seen, [51] nack_seen,
  // [67:52] bad_frames, [83:68] position_frames, [87:84] zero
  output logic [ubxr_pkg::TdataOutW-1:0] m_axis_tdata_o
);
  import ubxr_pkg::*;

  logic    in_valid_q;
  logic    [7:0] in_byte_q;
  logic    out_valid_q;
  result_t out_q;
  result_t res;
  logic    advance;
  logic    in_accept;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  ubxr_parser #(
    .MaxPayload(MAX_PAYLOAD)
  ) u_parser (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .byte_i(in_byte_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0,
                            out_q.position_frames,
                            out_q.bad_frames,
                            out_q.nack_seen,
                            out_q.ack_seen,
                            out_q.payload_length,
                            out_q.msg_id,
                            out_q.msg_class,
                            out_q.frame_status,
                            out_q.payload_index,
                            out_q.payload_byte,
                            out_q.payload_valid};

endmodule

// ----- hw/rtl/ubxr_parser.sv -----
// Frame state machine, Fletcher checksum and counters for one byte per step.
module ubxr_parser #(
  parameter int unsigned MaxPayload = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  output ubxr_pkg::result_t res_o
);
  import ubxr_pkg::*;

  localparam int unsigned CntW = $clog2(MaxPayload + 1);
  localparam logic [15:0] MaxLen = 16'(MaxPayload);

  localparam logic [3:0] PhIdle  = 4'd0;
  localparam logic [3:0] PhSync1 = 4'd1;
  localparam logic [3:0] PhClass = 4'd2;
  localparam logic [3:0] PhId    = 4'd3;
  localparam logic [3:0] PhLenLo = 4'd4;
  localparam logic [3:0] PhLenHi = 4'd5;
  localparam logic [3:0] PhPay   = 4'd6;
  localparam logic [3:0] PhCkA   = 4'd7;
  localparam logic [3:0] PhCkB   = 4'd8;

  logic [3:0]      phase_q, phase_d;
  logic [7:0]      class_q, class_d;
  logic [7:0]      id_q, id_d;
  logic [15:0]     len_q, len_d;
  logic [7:0]      sum_a_q, sum_a_d;
  logic [7:0]      sum_b_q, sum_b_d;
  logic [7:0]      rx_a_q, rx_a_d;
  logic [15:0]     bad_q, bad_d;
  logic [15:0]     pos_q, pos_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] cnt_inc;
  logic [15:0]     cnt_ext;
  logic [15:0]     len_hi_new;
  logic [7:0]      add_a, add_b;

  logic        pv;
  logic [7:0]  pb;
  logic [6:0]  pi;
  logic [1:0]  st;
  logic        ack, nack;

  assign add_a      = sum_a_q + byte_i;
  assign add_b      = sum_b_q + add_a;
  assign cnt_inc    = cnt_q + CntW'(1);
  assign cnt_ext    = 16'(cnt_q);
  assign len_hi_new = {byte_i, len_q[7:0]};

  always_comb begin
    phase_d = phase_q;
    class_d = class_q;
    id_d    = id_q;
    len_d   = len_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    rx_a_d  = rx_a_q;
    bad_d   = bad_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    pv      = 1'b0;
    pb      = 8'd0;
    pi      = 7'd0;
    st      = StatNone;
    ack     = 1'b0;
    nack    = 1'b0;
    unique case (phase_q)
      PhIdle, PhSync1: begin
        if (byte_i == Sync1Byte) begin
          phase_d = PhSync1;
        end else if (phase_q == PhSync1 && byte_i == Sync2Byte) begin
          phase_d = PhClass;
        end else begin
          phase_d = PhIdle;
        end
      end
      PhClass: begin
        class_d = byte_i;
        id_d    = 8'd0;
        len_d   = 16'd0;
        // sums restart from zero
        sum_a_d = byte_i;
        sum_b_d = byte_i;
        phase_d = PhId;
      end
      PhId: begin
        id_d    = byte_i;
        sum_a_d = add_a;
        sum_b_d = add_b;
        phase_d = PhLenLo;
      end
      PhLenLo: begin
        len_d   = {8'd0, byte_i};
        sum_a_d = add_a;
        sum_b_d = add_b;
        phase_d = PhLenHi;
      end
      PhLenHi: begin
        len_d   = len_hi_new;
        sum_a_d = add_a;
        sum_b_d = add_b;
        if (len_hi_new > MaxLen) begin
          st      = StatDrop;
          phase_d = PhIdle;
        end else begin
          cnt_d   = '0;
          phase_d = (len_hi_new != 16'd0) ? PhPay : PhCkA;
        end
      end
      PhPay: begin
        pv      = 1'b1;
        pb      = byte_i;
        pi      = cnt_ext[6:0];
        sum_a_d = add_a;
        sum_b_d = add_b;
        cnt_d   = cnt_inc;
        if (16'(cnt_inc) >= len_q) begin
          phase_d = PhCkA;
        end
      end
      PhCkA: begin
        rx_a_d  = byte_i;
        phase_d = PhCkB;
      end
      PhCkB: begin
        if (rx_a_q == sum_a_q && byte_i == sum_b_q) begin
          st = StatGood;
          if (class_q == ClassNav && id_q == IdNavPos) begin
            pos_d = pos_q + 16'd1;
          end
          ack  = (class_q == ClassAck) && (id_q == IdAck);
          nack = (class_q == ClassAck) && (id_q == IdNack);
        end else begin
          st    = StatBad;
          bad_d = bad_q + 16'd1;
        end
        phase_d = PhIdle;
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      class_q <= '0;
      id_q    <= '0;
      len_q   <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      rx_a_q  <= '0;
      bad_q   <= '0;
      pos_q   <= '0;
      cnt_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      class_q <= class_d;
      id_q    <= id_d;
      len_q   <= len_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      rx_a_q  <= rx_a_d;
      bad_q   <= bad_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    res_o.payload_valid   = pv;
    res_o.payload_byte    = pb;
    res_o.payload_index   = pi;
    res_o.frame_status    = st;
    res_o.msg_class       = class_d;
    res_o.msg_id          = id_d;
    res_o.payload_length  = len_d;
    res_o.ack_seen        = ack;
    res_o.nack_seen       = nack;
    res_o.bad_frames      = bad_d;
    res_o.position_frames = pos_d;
  end

endmodule
